>>> rtl/hsva_pkg.sv
// Shared constants, stage word types and sector codes for the HSV to ARGB converter.
`default_nettype none
package hsva_pkg;

   localparam int FRAC_BITS = 16;

   localparam int HUE_W   = 16;
   localparam int LEVEL_W = 17;
   localparam int ALPHA_W = 8;
   localparam int ARGB_W  = 32;

   localparam int SECTOR_W = 3;
   localparam int H6_W     = FRAC_BITS + 3;
   localparam int XS_W     = (FRAC_BITS + 2 > 18) ? FRAC_BITS + 2 : 18;
   localparam int FAC_W    = FRAC_BITS + 1;
   localparam int TERM_W   = LEVEL_W + 1;

   localparam logic [H6_W-1:0] HUE_SIX = H6_W'(6);
   localparam logic [XS_W-1:0] ONE_XS  = XS_W'(1) << FRAC_BITS;
   localparam logic [FAC_W-1:0] ONE_FAC = FAC_W'(1) << FRAC_BITS;

   localparam logic [SECTOR_W-1:0] SECTOR_RED_YELLOW   = 3'd0;
   localparam logic [SECTOR_W-1:0] SECTOR_YELLOW_GREEN = 3'd1;
   localparam logic [SECTOR_W-1:0] SECTOR_GREEN_CYAN   = 3'd2;
   localparam logic [SECTOR_W-1:0] SECTOR_CYAN_BLUE    = 3'd3;
   localparam logic [SECTOR_W-1:0] SECTOR_BLUE_MAGENTA = 3'd4;

   typedef struct packed {
      logic [SECTOR_W-1:0]  sector;
      logic [FRAC_BITS-1:0] frac;
      logic [LEVEL_W-1:0]   sat;
      logic [LEVEL_W-1:0]   val;
      logic [ALPHA_W-1:0]   alpha;
   } sector_word_type;

   typedef struct packed {
      logic [SECTOR_W-1:0] sector;
      logic [XS_W-1:0]     xs_p;
      logic [XS_W-1:0]     xs_q;
      logic [XS_W-1:0]     xs_t;
      logic [LEVEL_W-1:0]  val;
      logic [ALPHA_W-1:0]  alpha;
   } xs_word_type;

   typedef struct packed {
      logic [SECTOR_W-1:0] sector;
      logic [FAC_W-1:0]    fac_p;
      logic [FAC_W-1:0]    fac_q;
      logic [FAC_W-1:0]    fac_t;
      logic [LEVEL_W-1:0]  val;
      logic [ALPHA_W-1:0]  alpha;
   } fac_word_type;

   typedef struct packed {
      logic [SECTOR_W-1:0] sector;
      logic [TERM_W-1:0]   term_p;
      logic [TERM_W-1:0]   term_q;
      logic [TERM_W-1:0]   term_t;
      logic [LEVEL_W-1:0]  val;
      logic [ALPHA_W-1:0]  alpha;
   } term_word_type;

endpackage
`default_nettype wire

>>> rtl/hsva_sector.sv
// First stage: hue times six split into sector and fraction.
`default_nettype none
module hsva_sector (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         in_valid,
   output logic                              in_ready,
   input  wire logic [hsva_pkg::HUE_W-1:0]   in_hue,
   input  wire logic [hsva_pkg::LEVEL_W-1:0] in_sat,
   input  wire logic [hsva_pkg::LEVEL_W-1:0] in_val,
   input  wire logic [hsva_pkg::ALPHA_W-1:0] in_alpha,
   output logic                              out_valid,
   input  wire logic                         out_ready,
   output hsva_pkg::sector_word_type         out_word
);
   import hsva_pkg::*;

   logic            valid_ff;
   sector_word_type word_ff;
   sector_word_type word_in;
   logic [H6_W-1:0] hue_ext;
   logic [H6_W-1:0] h6;

   // mask to the fraction bits wraps hue modulo one turn
   always_comb begin
      hue_ext        = H6_W'(in_hue) & H6_W'(ONE_FAC - FAC_W'(1));
      h6             = hue_ext * HUE_SIX;
      word_in.sector = h6[H6_W-1:FRAC_BITS];
      word_in.frac   = h6[FRAC_BITS-1:0];
      word_in.sat    = in_sat;
      word_in.val    = in_val;
      word_in.alpha  = in_alpha;
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_word  = word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         word_ff <= word_in;
      end
   end

endmodule
`default_nettype wire

>>> rtl/hsva_terms.sv
// Stages two to four: inner products, factors and the p, q, t terms.
`default_nettype none
module hsva_terms (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      in_valid,
   output logic                           in_ready,
   input  wire hsva_pkg::sector_word_type in_word,
   output logic                           out_valid,
   input  wire logic                      out_ready,
   output hsva_pkg::term_word_type        out_word
);
   import hsva_pkg::*;

   logic          xs_valid_ff;
   logic          fac_valid_ff;
   logic          term_valid_ff;
   logic          xs_ready;
   logic          fac_ready;
   logic          term_ready;
   xs_word_type   xs_ff;
   xs_word_type   xs_in;
   fac_word_type  fac_ff;
   fac_word_type  fac_in;
   term_word_type term_ff;
   term_word_type term_in;

   logic [FRAC_BITS+LEVEL_W-1:0]  prod_q;
   logic [FAC_W-1:0]              one_minus_f;
   logic [FAC_W+LEVEL_W-1:0]      prod_t;
   logic [FAC_W+LEVEL_W-1:0]      prod_vp;
   logic [FAC_W+LEVEL_W-1:0]      prod_vq;
   logic [FAC_W+LEVEL_W-1:0]      prod_vt;

   function automatic logic [FAC_W-1:0] factor(input logic [XS_W-1:0] xs);
      logic [XS_W-1:0] diff;
      diff = ONE_XS - xs;
      if (xs >= ONE_XS) begin
         return '0;
      end
      return diff[FAC_W-1:0];
   endfunction

   always_comb begin
      prod_q       = (FRAC_BITS+LEVEL_W)'(in_word.frac) * (FRAC_BITS+LEVEL_W)'(in_word.sat);
      one_minus_f  = ONE_FAC - FAC_W'(in_word.frac);
      prod_t       = (FAC_W+LEVEL_W)'(one_minus_f) * (FAC_W+LEVEL_W)'(in_word.sat);
      xs_in.sector = in_word.sector;
      xs_in.xs_p   = XS_W'(in_word.sat);
      xs_in.xs_q   = XS_W'(prod_q >> FRAC_BITS);
      xs_in.xs_t   = XS_W'(prod_t >> FRAC_BITS);
      xs_in.val    = in_word.val;
      xs_in.alpha  = in_word.alpha;
   end

   always_comb begin
      fac_in.sector = xs_ff.sector;
      fac_in.fac_p  = factor(xs_ff.xs_p);
      fac_in.fac_q  = factor(xs_ff.xs_q);
      fac_in.fac_t  = factor(xs_ff.xs_t);
      fac_in.val    = xs_ff.val;
      fac_in.alpha  = xs_ff.alpha;
   end

   always_comb begin
      prod_vp        = (FAC_W+LEVEL_W)'(fac_ff.val) * (FAC_W+LEVEL_W)'(fac_ff.fac_p);
      prod_vq        = (FAC_W+LEVEL_W)'(fac_ff.val) * (FAC_W+LEVEL_W)'(fac_ff.fac_q);
      prod_vt        = (FAC_W+LEVEL_W)'(fac_ff.val) * (FAC_W+LEVEL_W)'(fac_ff.fac_t);
      term_in.sector = fac_ff.sector;
      term_in.term_p = TERM_W'(prod_vp >> FRAC_BITS);
      term_in.term_q = TERM_W'(prod_vq >> FRAC_BITS);
      term_in.term_t = TERM_W'(prod_vt >> FRAC_BITS);
      term_in.val    = fac_ff.val;
      term_in.alpha  = fac_ff.alpha;
   end

   assign term_ready = !term_valid_ff || out_ready;
   assign fac_ready  = !fac_valid_ff || term_ready;
   assign xs_ready   = !xs_valid_ff || fac_ready;
   assign in_ready   = xs_ready;
   assign out_valid  = term_valid_ff;
   assign out_word   = term_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         xs_valid_ff   <= 1'b0;
         fac_valid_ff  <= 1'b0;
         term_valid_ff <= 1'b0;
      end else begin
         if (xs_ready) begin
            xs_valid_ff <= in_valid;
         end
         if (fac_ready) begin
            fac_valid_ff <= xs_valid_ff;
         end
         if (term_ready) begin
            term_valid_ff <= fac_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (xs_ready && in_valid) begin
         xs_ff <= xs_in;
      end
      if (fac_ready && xs_valid_ff) begin
         fac_ff <= fac_in;
      end
      if (term_ready && fac_valid_ff) begin
         term_ff <= term_in;
      end
   end

endmodule
`default_nettype wire

>>> rtl/hsva_pack.sv
// Last stage: sector selection, byte scaling with clamp, and ARGB packing.
`default_nettype none
module hsva_pack (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        in_valid,
   output logic                             in_ready,
   input  wire hsva_pkg::term_word_type     in_word,
   output logic                             out_valid,
   input  wire logic                        out_stall,
   output logic [hsva_pkg::ARGB_W-1:0]      out_argb
);
   import hsva_pkg::*;

   logic              valid_ff;
   logic [ARGB_W-1:0] argb_ff;
   logic [ARGB_W-1:0] argb_in;
   logic [TERM_W-1:0] val_ext;
   logic [TERM_W-1:0] red;
   logic [TERM_W-1:0] green;
   logic [TERM_W-1:0] blue;

   function automatic logic [7:0] to_byte(input logic [TERM_W-1:0] c);
      logic [TERM_W+7:0] scaled;
      logic [TERM_W+7:0] whole;
      scaled = ({c, 8'h00}) - (TERM_W+8)'(c);
      whole  = scaled >> FRAC_BITS;
      if (whole > (TERM_W+8)'(8'hFF)) begin
         return 8'hFF;
      end
      return whole[7:0];
   endfunction

   always_comb begin
      val_ext = TERM_W'(in_word.val);
      case (in_word.sector)
         SECTOR_RED_YELLOW: begin
            red = val_ext;        green = in_word.term_t; blue = in_word.term_p;
         end
         SECTOR_YELLOW_GREEN: begin
            red = in_word.term_q; green = val_ext;        blue = in_word.term_p;
         end
         SECTOR_GREEN_CYAN: begin
            red = in_word.term_p; green = val_ext;        blue = in_word.term_t;
         end
         SECTOR_CYAN_BLUE: begin
            red = in_word.term_p; green = in_word.term_q; blue = val_ext;
         end
         SECTOR_BLUE_MAGENTA: begin
            red = in_word.term_t; green = in_word.term_p; blue = val_ext;
         end
         default: begin
            red = val_ext;        green = in_word.term_p; blue = in_word.term_q;
         end
      endcase
      argb_in = {in_word.alpha, to_byte(red), to_byte(green), to_byte(blue)};
   end

   assign in_ready  = !valid_ff || !out_stall;
   assign out_valid = valid_ff;
   assign out_argb  = argb_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         argb_ff <= argb_in;
      end
   end

endmodule
`default_nettype wire

>>> rtl/hsv_to_argb_converter_top.sv
// HSV to ARGB converter: five-stage pipeline from request word to response word.
// Throughput: one word per cycle while rsp_stall is low; each stage register holds while the stage after it is full
// and stalled, so bubbles collapse and req_stall rises only when all five stages are full.
// Reset clears the stage valid bits only; data registers are not reset.
`default_nettype none
module hsv_to_argb_converter_top (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [hsva_pkg::HUE_W-1:0]   req_hue_fraction,
   input  wire logic [hsva_pkg::LEVEL_W-1:0] req_saturation_level,
   input  wire logic [hsva_pkg::LEVEL_W-1:0] req_brightness_level,
   input  wire logic [hsva_pkg::ALPHA_W-1:0] req_alpha_byte,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic [hsva_pkg::ARGB_W-1:0]       rsp_argb_word
);
   import hsva_pkg::*;

   logic            req_ready;
   logic            sec_valid;
   logic            sec_ready;
   sector_word_type sec_word;
   logic            term_valid;
   logic            term_ready;
   term_word_type   term_word;

   hsva_sector u_sector (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_hue    (req_hue_fraction),
      .in_sat    (req_saturation_level),
      .in_val    (req_brightness_level),
      .in_alpha  (req_alpha_byte),
      .out_valid (sec_valid),
      .out_ready (sec_ready),
      .out_word  (sec_word)
   );

   hsva_terms u_terms (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sec_valid),
      .in_ready  (sec_ready),
      .in_word   (sec_word),
      .out_valid (term_valid),
      .out_ready (term_ready),
      .out_word  (term_word)
   );

   hsva_pack u_pack (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (term_valid),
      .in_ready  (term_ready),
      .in_word   (term_word),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_argb  (rsp_argb_word)
   );

   assign req_stall = !req_ready;

endmodule
`default_nettype wire

>>> test/argb_word_checker.sv
// Watches both channels of the HSV to ARGB converter, predicts each ARGB word and compares.
`timescale 1ns / 1ps
module argb_word_checker (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   input  wire logic                         req_stall,
   input  wire logic [hsva_pkg::HUE_W-1:0]   req_hue_fraction,
   input  wire logic [hsva_pkg::LEVEL_W-1:0] req_saturation_level,
   input  wire logic [hsva_pkg::LEVEL_W-1:0] req_brightness_level,
   input  wire logic [hsva_pkg::ALPHA_W-1:0] req_alpha_byte,
   input  wire logic                         rsp_valid,
   input  wire logic                         rsp_stall,
   input  wire logic [hsva_pkg::ARGB_W-1:0]  rsp_argb_word,
   output int                                fail_count,
   output int                                due_count,
   output int                                word_count
);
   import hsva_pkg::*;

   logic [ARGB_W-1:0] argb_due[$];

   // v * (1 - x*s), inner product truncated; zero once the factor reaches zero or below
   function automatic longint unsigned faded_level(input longint unsigned lvl,
                                                   input longint unsigned x,
                                                   input longint unsigned sat);
      longint unsigned one;
      longint unsigned xs;
      one = 64'd1 << FRAC_BITS;
      xs  = (x * sat) >> FRAC_BITS;
      if (xs >= one) begin
         return 0;
      end
      return (lvl * (one - xs)) >> FRAC_BITS;
   endfunction

   function automatic logic [7:0] channel_byte(input longint unsigned level);
      longint unsigned scaled;
      scaled = (level * 255) >> FRAC_BITS;
      return (scaled > 255) ? 8'hFF : scaled[7:0];
   endfunction

   function automatic logic [ARGB_W-1:0] argb_for(input logic [HUE_W-1:0]   hue,
                                                  input logic [LEVEL_W-1:0] sat,
                                                  input logic [LEVEL_W-1:0] val,
                                                  input logic [ALPHA_W-1:0] alpha);
      longint unsigned one;
      longint unsigned h6;
      longint unsigned f;
      longint unsigned v;
      longint unsigned p;
      longint unsigned q;
      longint unsigned t;
      longint unsigned r;
      longint unsigned g;
      longint unsigned b;
      logic [SECTOR_W-1:0] sector;
      one    = 64'd1 << FRAC_BITS;
      h6     = hue;
      h6     = (h6 & (one - 1)) * 6;
      sector = SECTOR_W'(h6 >> FRAC_BITS);
      f      = h6 & (one - 1);
      v      = val;
      p      = faded_level(v, one, sat);
      q      = faded_level(v, f, sat);
      t      = faded_level(v, one - f, sat);
      case (sector)
         SECTOR_RED_YELLOW: begin
            r = v; g = t; b = p;
         end
         SECTOR_YELLOW_GREEN: begin
            r = q; g = v; b = p;
         end
         SECTOR_GREEN_CYAN: begin
            r = p; g = v; b = t;
         end
         SECTOR_CYAN_BLUE: begin
            r = p; g = q; b = v;
         end
         SECTOR_BLUE_MAGENTA: begin
            r = t; g = p; b = v;
         end
         default: begin
            r = v; g = p; b = q;
         end
      endcase
      return {alpha, channel_byte(r), channel_byte(g), channel_byte(b)};
   endfunction

   always @(posedge clock) begin
      logic [ARGB_W-1:0] wanted;
      if (reset) begin
         fail_count <= 0;
         due_count  <= 0;
         word_count <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            argb_due.push_back(argb_for(req_hue_fraction, req_saturation_level,
                                        req_brightness_level, req_alpha_byte));
         end
         if (rsp_valid && !rsp_stall) begin
            word_count <= word_count + 1;
            if (argb_due.size() == 0) begin
               $display("%0t: unexpected word, actual %08h", $time, rsp_argb_word);
               fail_count <= fail_count + 1;
            end else begin
               wanted = argb_due.pop_front();
               if (wanted !== rsp_argb_word) begin
                  $display("%0t: argb_word mismatch, expected %08h, actual %08h",
                           $time, wanted, rsp_argb_word);
                  fail_count <= fail_count + 1;
               end
            end
         end
         due_count <= argb_due.size();
      end
   end

endmodule

>>> test/testbench.sv
// Stimulus and verdict for the HSV to ARGB converter, with the word checker alongside.
`timescale 1ns / 1ps
module testbench;
   import hsva_pkg::*;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [HUE_W-1:0]   req_hue_fraction = '0;
   logic [LEVEL_W-1:0] req_saturation_level = '0;
   logic [LEVEL_W-1:0] req_brightness_level = '0;
   logic [ALPHA_W-1:0] req_alpha_byte = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [ARGB_W-1:0]  rsp_argb_word;

   int fail_count;
   int due_count;
   int word_count;
   int colours_sent = 0;
   bit steady = 1'b0;

   always #5 clock = ~clock;

   hsv_to_argb_converter_top dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_hue_fraction     (req_hue_fraction),
      .req_saturation_level (req_saturation_level),
      .req_brightness_level (req_brightness_level),
      .req_alpha_byte       (req_alpha_byte),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_argb_word        (rsp_argb_word)
   );

   argb_word_checker checker_i (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_hue_fraction     (req_hue_fraction),
      .req_saturation_level (req_saturation_level),
      .req_brightness_level (req_brightness_level),
      .req_alpha_byte       (req_alpha_byte),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_argb_word        (rsp_argb_word),
      .fail_count           (fail_count),
      .due_count            (due_count),
      .word_count           (word_count)
   );

   function automatic int unsigned idle_cycles();
      return steady ? 0 : $urandom_range(0, 7);
   endfunction

   // mostly in range, with edges and some over-range levels
   function automatic logic [LEVEL_W-1:0] pick_level();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 60) return LEVEL_W'($urandom_range(0, 65536));
      if (pick < 72) return LEVEL_W'($urandom_range(0, 255));
      if (pick < 82) return LEVEL_W'(65536 - $urandom_range(0, 255));
      if (pick < 92) return $urandom_range(0, 1) ? LEVEL_W'(65536) : LEVEL_W'(0);
      return LEVEL_W'($urandom_range(65537, 131071));
   endfunction

   function automatic logic [HUE_W-1:0] pick_hue();
      int unsigned k;
      if ($urandom_range(0, 4) != 0) return HUE_W'($urandom_range(0, 65535));
      k = $urandom_range(1, 5);
      return HUE_W'((k * 65536 + 5) / 6 + $urandom_range(0, 6) - 3);
   endfunction

   task automatic offer_colour(input logic [HUE_W-1:0]   hue,
                               input logic [LEVEL_W-1:0] sat,
                               input logic [LEVEL_W-1:0] val,
                               input logic [ALPHA_W-1:0] alpha);
      int unsigned gap;
      gap = idle_cycles();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_hue_fraction     <= hue;
      req_saturation_level <= sat;
      req_brightness_level <= val;
      req_alpha_byte       <= alpha;
      req_valid            <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      colours_sent++;
   endtask

   // receiver: random stalls per word, plus a long hold-off every 500 words
   initial begin
      int unsigned hold;
      int          taken;
      taken = 0;
      while (reset) @(posedge clock);
      forever begin
         hold = idle_cycles();
         if (taken != 0 && taken % 500 == 0) hold = 48;
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         taken++;
      end
   end

   initial begin
      #2ms;
      $display("FAIL");
      $finish;
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      offer_colour(16'd0,     17'd65536,  17'd65536,  8'hFF);
      offer_colour(16'd0,     17'd0,      17'd0,      8'h00);
      offer_colour(16'd65535, 17'd65536,  17'd65536,  8'hA5);
      offer_colour(16'd10922, 17'd65536,  17'd65536,  8'h5A);
      offer_colour(16'd10923, 17'd65536,  17'd65536,  8'h01);
      offer_colour(16'd21846, 17'd65536,  17'd65536,  8'h80);
      offer_colour(16'd32767, 17'd65536,  17'd65536,  8'h7F);
      offer_colour(16'd32768, 17'd65536,  17'd65536,  8'hFE);
      offer_colour(16'd43691, 17'd65536,  17'd65536,  8'h33);
      offer_colour(16'd54614, 17'd65536,  17'd65536,  8'hCC);
      offer_colour(16'd20000, 17'd0,      17'd65536,  8'hFF);
      offer_colour(16'd50000, 17'd65536,  17'd0,      8'h00);
      offer_colour(16'd5000,  17'd131071, 17'd65536,  8'h11);
      offer_colour(16'd30000, 17'd98304,  17'd65536,  8'h22);
      offer_colour(16'd40000, 17'd0,      17'd131071, 8'h44);
      offer_colour(16'd45000, 17'd32768,  17'd131071, 8'h88);
      offer_colour(16'd60000, 17'd65536,  17'd98304,  8'h99);
      offer_colour(16'd1,     17'd65535,  17'd65535,  8'hEE);
      offer_colour(16'd65534, 17'd1,      17'd1,      8'h10);
      offer_colour(16'd12345, 17'd131071, 17'd131071, 8'h55);

      for (int i = 0; i < 1600; i++) begin
         steady = ((i / 200) % 2) == 1;
         offer_colour(pick_hue(), pick_level(), pick_level(), ALPHA_W'($urandom_range(0, 255)));
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (due_count != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Sent %0d colours: edges of every field, all six hue sectors, over-range",
               colours_sent);
      $display("saturation and value; %0d words checked under random gaps and hold-offs.",
               word_count);
      if (fail_count == 0 && due_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/hsva_pkg.sv
rtl/hsva_sector.sv
rtl/hsva_terms.sv
rtl/hsva_pack.sv
rtl/hsv_to_argb_converter_top.sv
test/argb_word_checker.sv
test/testbench.sv
